// ===== rtl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants of the serial interface device
// Command codes, error codes, status bit positions and the transfer structs
// exchanged between the input stage, the command core and the result stage.
// ----------------------------------------------------------------------------
package sid_pkg;

  // command codes carried by one input transfer
  typedef enum logic [2:0] {
    CMD_QUERY     = 3'd0,
    CMD_CONFIGURE = 3'd1,
    CMD_READ      = 3'd2,
    CMD_TRANSMIT  = 3'd3,
    CMD_IRQ_SETUP = 3'd4,
    CMD_LINE_RX   = 3'd5,
    CMD_CONNECT   = 3'd6
  } cmd_t;

  // error codes returned in register C
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_BUSY     = 2'd2,
    ERR_NO_DATA  = 2'd3
  } err_t;

  // status word bit positions
  localparam int unsigned ST_DISCONN    = 0;
  localparam int unsigned ST_RX_FULL    = 2;
  localparam int unsigned ST_TX_FREE    = 4;
  localparam int unsigned ST_RX_IRQ_ON  = 14;
  localparam int unsigned ST_TX_IRQ_ON  = 15;

  // irq enable bits in register B on irq setup
  localparam int unsigned IRQ_EN_RX = 0;
  localparam int unsigned IRQ_EN_TX = 1;

  localparam int unsigned OCT_W = 3;

  // one command as it enters the block
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] reg_b;
    logic [15:0] reg_c;
    logic [15:0] reg_x;
    logic [31:0] line_word;
    logic        port_connected;
  } item_t;

  // one result as it leaves the block
  typedef struct packed {
    logic        a_write;
    logic [15:0] reg_a_out;
    logic        b_write;
    logic [15:0] reg_b_out;
    logic        c_write;
    logic [1:0]  error_code;
    logic        send_valid;
    logic [31:0] send_word;
    logic        irq_valid;
    logic [15:0] irq_message;
  } res_t;

  // mask of the bits a received word may use for a given octet count
  function automatic logic [31:0] width_mask(input logic [OCT_W-1:0] octets);
    logic [31:0] m;
    case (octets)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/sid_in_reg.sv =====
// ----------------------------------------------------------------------------
// sid_in_reg: input register
// Captures one command transfer and holds it until the command core takes it.
// ----------------------------------------------------------------------------
module sid_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sid_pkg::item_t in_item,
  output logic           hold_valid,
  output sid_pkg::item_t hold_item,
  input  logic           take
);

  logic           valid_r;
  logic           valid_nxt;
  sid_pkg::item_t item_r;
  logic           accept;

  // stall only while a held item cannot move on this cycle
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  // occupancy of the register
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// ===== rtl/sid_core.sv =====
// ----------------------------------------------------------------------------
// sid_core: command core
// Holds the device state and works out the result of one command in a single
// pass; state is updated when the command is handed to the result stage.
// ----------------------------------------------------------------------------
module sid_core #(
  parameter int unsigned MAX_OCTETS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           exec,
  input  sid_pkg::item_t item,
  output sid_pkg::res_t  res
);

  localparam logic [sid_pkg::OCT_W-1:0] MaxOct = sid_pkg::OCT_W'(MAX_OCTETS);

  logic [31:0] rx_word_r, rx_word_nxt;
  logic        rx_full_r, rx_full_nxt;
  logic        rx_overflow_r, rx_overflow_nxt;
  logic [sid_pkg::OCT_W-1:0] word_octets_r, word_octets_nxt;
  logic        tx_pending_r, tx_pending_nxt;
  logic [31:0] tx_word_r, tx_word_nxt;
  logic [15:0] rx_irq_msg_r, rx_irq_msg_nxt;
  logic [15:0] tx_irq_msg_r, tx_irq_msg_nxt;

  sid_pkg::cmd_t cmd;
  logic [31:0]   mask;
  logic [31:0]   tx_data;

  assign cmd     = sid_pkg::cmd_t'(item.cmd);
  assign mask    = sid_pkg::width_mask(word_octets_r);
  assign tx_data = {item.reg_c, item.reg_b};

  // result and next state of one command
  always_comb begin
    res             = '0;
    rx_word_nxt     = rx_word_r;
    rx_full_nxt     = rx_full_r;
    rx_overflow_nxt = rx_overflow_r;
    word_octets_nxt = word_octets_r;
    tx_pending_nxt  = tx_pending_r;
    tx_word_nxt     = tx_word_r;
    rx_irq_msg_nxt  = rx_irq_msg_r;
    tx_irq_msg_nxt  = tx_irq_msg_r;
    case (cmd)
      sid_pkg::CMD_QUERY: begin
        res.a_write                          = 1'b1;
        res.reg_a_out[sid_pkg::ST_DISCONN]   = !item.port_connected;
        res.reg_a_out[sid_pkg::ST_RX_FULL]   = rx_full_r;
        res.reg_a_out[sid_pkg::ST_TX_FREE]   = !tx_pending_r;
        res.reg_a_out[sid_pkg::ST_RX_IRQ_ON] = |rx_irq_msg_r;
        res.reg_a_out[sid_pkg::ST_TX_IRQ_ON] = |tx_irq_msg_r;
      end
      sid_pkg::CMD_CONFIGURE: begin
        // width saturates at the largest supported octet count
        if (item.reg_b >= 16'(MAX_OCTETS)) begin
          word_octets_nxt = MaxOct;
        end else begin
          word_octets_nxt = item.reg_b[sid_pkg::OCT_W-1:0] + 1'b1;
        end
      end
      sid_pkg::CMD_READ: begin
        res.a_write   = 1'b1;
        res.reg_a_out = rx_word_r[15:0];
        res.b_write   = 1'b1;
        res.reg_b_out = rx_word_r[31:16];
        res.c_write   = 1'b1;
        if (rx_overflow_r) begin
          res.error_code = sid_pkg::ERR_OVERFLOW;
        end else if (!rx_full_r) begin
          res.error_code = sid_pkg::ERR_NO_DATA;
        end else begin
          res.error_code = sid_pkg::ERR_NONE;
        end
        rx_word_nxt     = '0;
        rx_full_nxt     = 1'b0;
        rx_overflow_nxt = 1'b0;
      end
      sid_pkg::CMD_TRANSMIT: begin
        res.c_write = 1'b1;
        if (item.port_connected) begin
          res.error_code  = sid_pkg::ERR_NONE;
          res.send_valid  = 1'b1;
          res.send_word   = tx_data;
          res.irq_valid   = 1'b1;
          res.irq_message = tx_irq_msg_r;
        end else if (tx_pending_r) begin
          res.error_code = sid_pkg::ERR_OVERFLOW;
        end else begin
          res.error_code = sid_pkg::ERR_BUSY;
          tx_pending_nxt = 1'b1;
          tx_word_nxt    = tx_data;
        end
      end
      sid_pkg::CMD_IRQ_SETUP: begin
        rx_irq_msg_nxt = item.reg_b[sid_pkg::IRQ_EN_RX] ? item.reg_c : 16'd0;
        tx_irq_msg_nxt = item.reg_b[sid_pkg::IRQ_EN_TX] ? item.reg_x : 16'd0;
      end
      sid_pkg::CMD_LINE_RX: begin
        // overflow on a word already buffered or one wider than configured
        rx_overflow_nxt = rx_overflow_r || rx_full_r || ((item.line_word & ~mask) != '0);
        rx_word_nxt     = item.line_word & mask;
        rx_full_nxt     = 1'b1;
      end
      sid_pkg::CMD_CONNECT: begin
        // flush the queued word
        if (tx_pending_r) begin
          tx_pending_nxt  = 1'b0;
          res.send_valid  = 1'b1;
          res.send_word   = tx_word_r;
          res.irq_valid   = 1'b1;
          res.irq_message = tx_irq_msg_r;
        end
      end
      default: begin
      end
    endcase
  end

  // device state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_word_r     <= '0;
      rx_full_r     <= 1'b0;
      rx_overflow_r <= 1'b0;
      word_octets_r <= MaxOct;
      tx_pending_r  <= 1'b0;
      tx_word_r     <= '0;
      rx_irq_msg_r  <= '0;
      tx_irq_msg_r  <= '0;
    end else if (exec) begin
      rx_word_r     <= rx_word_nxt;
      rx_full_r     <= rx_full_nxt;
      rx_overflow_r <= rx_overflow_nxt;
      word_octets_r <= word_octets_nxt;
      tx_pending_r  <= tx_pending_nxt;
      tx_word_r     <= tx_word_nxt;
      rx_irq_msg_r  <= rx_irq_msg_nxt;
      tx_irq_msg_r  <= tx_irq_msg_nxt;
    end
  end

  // octet count stays within the supported range
  a_octets_range: assert property (@(posedge clk) disable iff (!rst_n)
    (word_octets_r != '0) && (word_octets_r <= MaxOct))
    else $error("word width out of range");

  // overflow is only ever flagged with a word buffered
  a_ovf_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    rx_overflow_r |-> rx_full_r)
    else $error("overflow flag without buffered word");

  // a read empties the receive buffer
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (cmd == sid_pkg::CMD_READ)) |=> (!rx_full_r && !rx_overflow_r))
    else $error("read did not clear receive buffer");

  // every link send raises the transmit interrupt
  a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> (res.send_valid == res.irq_valid))
    else $error("send without transmit interrupt");

endmodule

// ===== rtl/sid_out_reg.sv =====
// ----------------------------------------------------------------------------
// sid_out_reg: result register
// Holds one result until the consumer takes it; frees in the same cycle it
// is taken so a new result can be loaded behind it.
// ----------------------------------------------------------------------------
module sid_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          src_valid,
  output logic          load,
  input  sid_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_stall,
  output sid_pkg::res_t out_res
);

  logic          valid_r;
  logic          valid_nxt;
  sid_pkg::res_t res_r;

  // load when empty or when the held result leaves this cycle
  assign load = src_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/serial_interface_device_top.sv =====
// Serial interface device: one command transfer in, one result transfer out.
// A command is registered, decoded against the device state in one pass and
// its result registered; the state changes as the result is registered. A
// command passes through the input register and then the result register, and a
// new command is accepted every cycle while the result side keeps up. MAX_OCTETS
// is the widest receive word in octets (1 to 4) and also the width after reset.
// ----------------------------------------------------------------------------
// serial_interface_device_top: top level
// Input register, command core and result register of the serial link device.
// ----------------------------------------------------------------------------
module serial_interface_device_top #(
  parameter int unsigned MAX_OCTETS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_reg_b,
  input  logic [15:0] in_reg_c,
  input  logic [15:0] in_reg_x,
  input  logic [31:0] in_line_word,
  input  logic        in_port_connected,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_a_write,
  output logic [15:0] out_reg_a_out,
  output logic        out_b_write,
  output logic [15:0] out_reg_b_out,
  output logic        out_c_write,
  output logic [1:0]  out_error_code,
  output logic        out_send_valid,
  output logic [31:0] out_send_word,
  output logic        out_irq_valid,
  output logic [15:0] out_irq_message
);

  sid_pkg::item_t in_item;
  sid_pkg::item_t hold_item;
  sid_pkg::res_t  core_res;
  sid_pkg::res_t  out_res;
  logic           hold_valid;
  logic           load;

  // input transfer payload
  always_comb begin
    in_item.cmd            = in_cmd;
    in_item.reg_b          = in_reg_b;
    in_item.reg_c          = in_reg_c;
    in_item.reg_x          = in_reg_x;
    in_item.line_word      = in_line_word;
    in_item.port_connected = in_port_connected;
  end

  sid_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (load)
  );

  sid_core #(
    .MAX_OCTETS (MAX_OCTETS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (load),
    .item  (hold_item),
    .res   (core_res)
  );

  sid_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (hold_valid),
    .load      (load),
    .res       (core_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result transfer payload
  assign out_a_write     = out_res.a_write;
  assign out_reg_a_out   = out_res.reg_a_out;
  assign out_b_write     = out_res.b_write;
  assign out_reg_b_out   = out_res.reg_b_out;
  assign out_c_write     = out_res.c_write;
  assign out_error_code  = out_res.error_code;
  assign out_send_valid  = out_res.send_valid;
  assign out_send_word   = out_res.send_word;
  assign out_irq_valid   = out_res.irq_valid;
  assign out_irq_message = out_res.irq_message;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the serial interface device
// Drives command transfers through a valid/stall channel and checks every
// result transfer against a cycle-free model of the device kept in the bench,
// or a hand-typed result. A short stimulus table comes first, then weighted
// random commands with random gaps and stalls on both channels, one long
// result hold-off and pauses that let the device drain.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WIDEST       = 4;
  localparam int unsigned RANDOM_ITEMS = 1075;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 8;
  // command code with no function in the device
  localparam logic [2:0]  CMD_UNUSED   = 3'd7;

  // one row of the stimulus table, with an optional hand-typed result
  typedef struct packed {
    sid_pkg::item_t it;
    logic           typed;
    sid_pkg::res_t  res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [15:0] in_reg_b = '0;
  logic [15:0] in_reg_c = '0;
  logic [15:0] in_reg_x = '0;
  logic [31:0] in_line_word = '0;
  logic        in_port_connected = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_a_write;
  logic [15:0] out_reg_a_out;
  logic        out_b_write;
  logic [15:0] out_reg_b_out;
  logic        out_c_write;
  logic [1:0]  out_error_code;
  logic        out_send_valid;
  logic [31:0] out_send_word;
  logic        out_irq_valid;
  logic [15:0] out_irq_message;

  // device state as the bench sees it
  logic [31:0]               rx_buf    = '0;
  logic                      rx_held   = 1'b0;
  logic                      rx_ovf    = 1'b0;
  logic [sid_pkg::OCT_W-1:0] oct_width = sid_pkg::OCT_W'(WIDEST);
  logic                      tx_queued = 1'b0;
  logic [31:0]               tx_buf    = '0;
  logic [15:0]               rx_irq    = '0;
  logic [15:0]               tx_irq    = '0;

  sid_pkg::res_t expected_q[$];
  sid_pkg::res_t want_res;
  row_t          dir_rows[$];
  int unsigned   fail_count   = 0;
  int unsigned   quiet_cycles = 0;
  bit            hold_req     = 1'b0;
  bit            stall_free   = 1'b0;

  serial_interface_device_top #(
    .MAX_OCTETS(WIDEST)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_reg_b         (in_reg_b),
    .in_reg_c         (in_reg_c),
    .in_reg_x         (in_reg_x),
    .in_line_word     (in_line_word),
    .in_port_connected(in_port_connected),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_a_write      (out_a_write),
    .out_reg_a_out    (out_reg_a_out),
    .out_b_write      (out_b_write),
    .out_reg_b_out    (out_reg_b_out),
    .out_c_write      (out_c_write),
    .out_error_code   (out_error_code),
    .out_send_valid   (out_send_valid),
    .out_send_word    (out_send_word),
    .out_irq_valid    (out_irq_valid),
    .out_irq_message  (out_irq_message)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sid_pkg::item_t cmd_item(logic [2:0] cmd, logic [15:0] b,
                                              logic [15:0] c, logic [15:0] x,
                                              logic [31:0] word, logic conn);
    sid_pkg::item_t it;
    it.cmd            = cmd;
    it.reg_b          = b;
    it.reg_c          = c;
    it.reg_x          = x;
    it.line_word      = word;
    it.port_connected = conn;
    return it;
  endfunction

  // register results only; nothing sent, no interrupt
  function automatic sid_pkg::res_t typed_res(logic a_wr, logic [15:0] a, logic b_wr,
                                              logic [15:0] b, logic c_wr,
                                              sid_pkg::err_t err);
    sid_pkg::res_t r;
    r             = '0;
    r.a_write     = a_wr;
    r.reg_a_out   = a;
    r.b_write     = b_wr;
    r.reg_b_out   = b;
    r.c_write     = c_wr;
    r.error_code  = err;
    return r;
  endfunction

  // work out the result of one command and advance the device state
  task automatic predict_response(input sid_pkg::item_t it, output sid_pkg::res_t r);
    logic [15:0] status;
    logic [31:0] mask;
    logic [31:0] word;
    r = '0;
    case (it.cmd)
      sid_pkg::CMD_QUERY: begin
        status                        = '0;
        status[sid_pkg::ST_DISCONN]   = ~it.port_connected;
        status[sid_pkg::ST_RX_FULL]   = rx_held;
        status[sid_pkg::ST_TX_FREE]   = ~tx_queued;
        status[sid_pkg::ST_RX_IRQ_ON] = (rx_irq != 0);
        status[sid_pkg::ST_TX_IRQ_ON] = (tx_irq != 0);
        r.a_write                     = 1'b1;
        r.reg_a_out                   = status;
      end
      sid_pkg::CMD_CONFIGURE: begin
        if (it.reg_b >= WIDEST) oct_width = sid_pkg::OCT_W'(WIDEST);
        else oct_width = it.reg_b[sid_pkg::OCT_W-1:0] + 1'b1;
      end
      sid_pkg::CMD_READ: begin
        r.a_write   = 1'b1;
        r.reg_a_out = rx_buf[15:0];
        r.b_write   = 1'b1;
        r.reg_b_out = rx_buf[31:16];
        r.c_write   = 1'b1;
        if (rx_ovf) r.error_code = sid_pkg::ERR_OVERFLOW;
        else if (!rx_held) r.error_code = sid_pkg::ERR_NO_DATA;
        else r.error_code = sid_pkg::ERR_NONE;
        rx_buf  = '0;
        rx_held = 1'b0;
        rx_ovf  = 1'b0;
      end
      sid_pkg::CMD_TRANSMIT: begin
        word      = {it.reg_c, it.reg_b};
        r.c_write = 1'b1;
        if (it.port_connected) begin
          r.error_code  = sid_pkg::ERR_NONE;
          r.send_valid  = 1'b1;
          r.send_word   = word;
          r.irq_valid   = 1'b1;
          r.irq_message = tx_irq;
        end else if (tx_queued) begin
          r.error_code = sid_pkg::ERR_OVERFLOW;
        end else begin
          tx_queued    = 1'b1;
          tx_buf       = word;
          r.error_code = sid_pkg::ERR_BUSY;
        end
      end
      sid_pkg::CMD_IRQ_SETUP: begin
        rx_irq = it.reg_b[sid_pkg::IRQ_EN_RX] ? it.reg_c : 16'h0000;
        tx_irq = it.reg_b[sid_pkg::IRQ_EN_TX] ? it.reg_x : 16'h0000;
      end
      sid_pkg::CMD_LINE_RX: begin
        // a second word on a full buffer, or a word too wide, is an overflow
        if (rx_held) rx_ovf = 1'b1;
        if (oct_width >= WIDEST) mask = '1;
        else mask = (32'd1 << (8 * oct_width)) - 32'd1;
        word = it.line_word;
        if (word > mask) begin
          rx_ovf = 1'b1;
          word   = word & mask;
        end
        rx_buf  = word;
        rx_held = 1'b1;
      end
      sid_pkg::CMD_CONNECT: begin
        // flush the queued word, if any
        if (tx_queued) begin
          tx_queued     = 1'b0;
          r.send_valid  = 1'b1;
          r.send_word   = tx_buf;
          r.irq_valid   = 1'b1;
          r.irq_message = tx_irq;
        end
      end
      default: ;
    endcase
  endtask

  // offer one command and hold it until the transfer
  task automatic offer_item(input sid_pkg::item_t it, input logic typed,
                            input sid_pkg::res_t hand_res);
    sid_pkg::res_t pred;
    in_cmd            <= it.cmd;
    in_reg_b          <= it.reg_b;
    in_reg_c          <= it.reg_c;
    in_reg_x          <= it.reg_x;
    in_line_word      <= it.line_word;
    in_port_connected <= it.port_connected;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_response(it, pred);
    expected_q.push_back(typed ? hand_res : pred);
  endtask

  // sender gaps: mostly none or short, a few long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic sender_idle(input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering until every result has come back
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // weighted random command with random content
  function automatic sid_pkg::item_t random_command();
    sid_pkg::item_t it;
    int unsigned    r;
    it = cmd_item(sid_pkg::CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, 1'($urandom_range(0, 1)));
    r  = $urandom_range(0, 99);
    if (r < 10) it.cmd = sid_pkg::CMD_QUERY;
    else if (r < 16) it.cmd = sid_pkg::CMD_CONFIGURE;
    else if (r < 35) it.cmd = sid_pkg::CMD_READ;
    else if (r < 53) it.cmd = sid_pkg::CMD_TRANSMIT;
    else if (r < 59) it.cmd = sid_pkg::CMD_IRQ_SETUP;
    else if (r < 84) it.cmd = sid_pkg::CMD_LINE_RX;
    else if (r < 98) it.cmd = sid_pkg::CMD_CONNECT;
    else it.cmd = CMD_UNUSED;
    // widths near the octet range most of the time
    if (it.cmd == sid_pkg::CMD_CONFIGURE && $urandom_range(0, 9) < 7)
      it.reg_b = 16'($urandom_range(0, 5));
    // received words often fit one of the narrower widths
    r = $urandom_range(0, 9);
    if (r < 3) it.line_word = $urandom_range(0, 255);
    else if (r < 6) it.line_word = it.line_word >> (8 * $urandom_range(0, 3));
    return it;
  endfunction

  // receiver stalls: random segments, a calm stretch on request, one long hold-off
  initial begin
    int unsigned r;
    int unsigned n;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (stall_free || r < 55) begin
        out_stall <= 1'b0;
        n = stall_free ? 1 : $urandom_range(1, 8);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 30);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t  %s mismatch: expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t  result transfer with nothing expected", $time);
        fail_count++;
      end else begin
        want_res = expected_q.pop_front();
        check_field("a_write", 32'(want_res.a_write), 32'(out_a_write));
        check_field("reg_a_out", 32'(want_res.reg_a_out), 32'(out_reg_a_out));
        check_field("b_write", 32'(want_res.b_write), 32'(out_b_write));
        check_field("reg_b_out", 32'(want_res.reg_b_out), 32'(out_reg_b_out));
        check_field("c_write", 32'(want_res.c_write), 32'(out_c_write));
        check_field("error_code", 32'(want_res.error_code), 32'(out_error_code));
        check_field("send_valid", 32'(want_res.send_valid), 32'(out_send_valid));
        check_field("send_word", want_res.send_word, out_send_word);
        check_field("irq_valid", 32'(want_res.irq_valid), 32'(out_irq_valid));
        check_field("irq_message", 32'(want_res.irq_message), 32'(out_irq_message));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    // status and read straight after reset
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b0), 1'b1,
                         typed_res(1'b1, 16'h0011, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_READ, 0, 0, 0, 0, 1'b1), 1'b1,
                         typed_res(1'b1, 0, 1'b1, 0, 1'b1, sid_pkg::ERR_NO_DATA)});
    // both interrupt messages at their widest
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_IRQ_SETUP, 16'h0003, 16'hFFFF, 16'hFFFF,
                                  0, 1'b0),
                         1'b1, typed_res(1'b0, 0, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b1), 1'b1,
                         typed_res(1'b1, 16'hC010, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    // word on a full buffer
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'hFFFF_FFFF, 1'b0), 1'b1,
                         typed_res(1'b0, 0, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'h0000_0000, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_READ, 0, 0, 0, 0, 1'b0), 1'b1,
                         typed_res(1'b1, 0, 1'b1, 0, 1'b1, sid_pkg::ERR_OVERFLOW)});
    // narrowest width, word just too wide
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_CONFIGURE, 16'h0000, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'h0000_0100, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_READ, 0, 0, 0, 0, 1'b0), 1'b0, '0});
    // saturated width, full word
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_CONFIGURE, 16'hFFFF, 0, 0, 0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'hFFFF_FFFF, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_READ, 0, 0, 0, 0, 1'b1), 1'b0, '0});
    // three octets: exact fit, then too wide on a full buffer
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_CONFIGURE, 16'h0002, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'h00FF_FFFF, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_LINE_RX, 0, 0, 0, 32'h0100_0000, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_READ, 0, 0, 0, 0, 1'b0), 1'b0, '0});
    // transmit connected, queued, queue full
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_TRANSMIT, 16'hFFFF, 16'hFFFF, 0, 0, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_TRANSMIT, 16'h1234, 16'h5678, 0, 0, 1'b0),
                         1'b1, typed_res(1'b0, 0, 1'b0, 0, 1'b1, sid_pkg::ERR_BUSY)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_TRANSMIT, 16'h0000, 16'h0000, 0, 0, 1'b0),
                         1'b1, typed_res(1'b0, 0, 1'b0, 0, 1'b1, sid_pkg::ERR_OVERFLOW)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_QUERY, 0, 0, 0, 0, 1'b0), 1'b0, '0});
    // connect flushes the queue, then finds it empty
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_CONNECT, 0, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_CONNECT, 0, 0, 0, 0, 1'b1), 1'b1,
                         typed_res(1'b0, 0, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    // interrupt still raised with a zero message
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_IRQ_SETUP, 16'h0000, 16'hFFFF, 16'hFFFF,
                                  0, 1'b1),
                         1'b1, typed_res(1'b0, 0, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});
    dir_rows.push_back('{cmd_item(sid_pkg::CMD_TRANSMIT, 16'h0000, 16'h0000, 0, 0, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{cmd_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                  1'b1),
                         1'b1, typed_res(1'b0, 0, 1'b0, 0, 1'b0, sid_pkg::ERR_NONE)});

    // reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
      sender_idle(idle_gap());
    end
    drain_responses();

    // random commands
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 600) drain_responses();
      if (n == 700) stall_free = 1'b1;
      if (n == 800) stall_free = 1'b0;
      offer_item(random_command(), 1'b0, '0);
      // back-to-back during the hold-off and the calm stretch
      if (!((n >= 300 && n < 380) || (n >= 700 && n < 800)))
        sender_idle(idle_gap());
    end

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
